FILE: design/upa_pkg.sv
package upa_pkg;

   // command codes
   typedef enum logic [2:0] {
      CMD_ADD   = 3'd0,
      CMD_MUL   = 3'd1,
      CMD_DIV   = 3'd2,
      CMD_SCALE = 3'd3,
      CMD_LESS  = 3'd4,
      CMD_SIG   = 3'd5
   } cmd_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_SAT      = 2'd2
   } stat_type;

   localparam logic [30:0] MAX_ERR   = 31'h7FFF_FFFF;
   localparam logic [31:0] VAL_MAX   = 32'h7FFF_FFFF;
   localparam logic [31:0] VAL_MIN   = 32'h8000_0000;
   localparam int          SQRT_STEPS = 64;
   localparam int          DIV_STEPS  = 32;

   // per-word data riding along the root and divide sections
   typedef struct packed {
      cmd_type     cmd;
      logic        less;
      logic        vneg;        // sign of the quotient value
      logic        zdiv;        // zero divisor
      logic [31:0] early_val;   // value for add, multiply, scale
      logic        early_vsat;
      logic [30:0] early_err;   // error for add, multiply, scale
      logic        early_esat;
      logic [31:0] vd_n;        // magnitude of a_value, value dividend
      logic [31:0] vd_d;        // value divisor
      logic [62:0] ed_d;        // error divisor, b_value squared
   } carry_type;

endpackage

FILE: design/uncertainty_propagation_alu_top.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_stall | command, a_value, a_error, b_value, b_error
// rsp     | out       | rsp_valid, rsp_stall | result_value, result_error, less_flag, status
//
// One word enters per cycle while the pipeline is not stalled; every word gives one result.
// The pipeline holds the 64-stage square root (one root bit per stage)
// followed by the 32-stage restoring dividers (one quotient bit per stage).
// Synchronous active-high reset clears the valid bits of all stages.
// A stalled result freezes the whole pipeline; req_stall follows it.
module uncertainty_propagation_alu_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_a_value,
   input  logic [30:0]        req_a_error,
   input  logic signed [31:0] req_b_value,
   input  logic [30:0]        req_b_error,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic [30:0]        rsp_result_error,
   output logic               rsp_less_flag,
   output logic [1:0]         rsp_status
);
   import upa_pkg::*;

   logic adv;

   // ---------------- stage 0: operand capture ----------------
   logic        s0_v_ff;
   cmd_type     s0_cmd_ff;
   logic [31:0] s0_va_ff, s0_vb_ff, s0_mva_ff, s0_mvb_ff;
   logic [30:0] s0_ea_ff, s0_eb_ff;
   logic        s0_neg_ff, s0_less_ff;
   logic [31:0] s0_mva_in, s0_mvb_in;

   // ---------------- stage 1: products ----------------
   logic        s1_v_ff;
   cmd_type     s1_cmd_ff;
   logic [63:0] s1_prod_ff;
   logic [62:0] s1_p1_ff, s1_p2_ff, s1_d2_ff;
   logic [32:0] s1_sum_ff;
   logic        s1_neg_ff, s1_less_ff, s1_vneg_ff, s1_zdiv_ff;
   logic [30:0] s1_ea_ff, s1_eb_ff;
   logic [31:0] s1_mva_ff, s1_vd_d_ff;
   logic [63:0] s1_prod_in, s1_p1_in, s1_p2_in, s1_d2_in;

   // ---------------- stage 2: early results, square operands ----------------
   logic        s2_v_ff;
   carry_type   s2_c_ff, s2_c_in;
   logic [62:0] s2_x1_ff, s2_x2_ff;
   logic [47:0] s2_mag;
   logic [46:0] s2_serr;
   logic        s2_msat;

   // ---------------- stage 3: partial squares ----------------
   logic        s3_v_ff;
   carry_type   s3_c_ff;
   logic [63:0] s3_ll1_ff, s3_ll2_ff;
   logic [62:0] s3_lh1_ff, s3_lh2_ff;
   logic [61:0] s3_hh1_ff, s3_hh2_ff;

   // ---------------- stage 4: full squares ----------------
   logic         s4_v_ff;
   carry_type    s4_c_ff;
   logic [127:0] s4_sq1_ff, s4_sq2_ff;

   // ---------------- square root section ----------------
   logic         sq_v_ff    [0:SQRT_STEPS];
   carry_type    sq_c_ff    [0:SQRT_STEPS];
   logic [127:0] sq_n_ff    [0:SQRT_STEPS];
   logic [64:0]  sq_rem_ff  [0:SQRT_STEPS];
   logic [63:0]  sq_root_ff [0:SQRT_STEPS];

   // ---------------- divide section ----------------
   logic        dv_v_ff    [0:DIV_STEPS];
   carry_type   dv_c_ff    [0:DIV_STEPS];
   logic [62:0] ev_rem_ff  [0:DIV_STEPS];
   logic [31:0] ev_bits_ff [0:DIV_STEPS];
   logic [31:0] ev_q_ff    [0:DIV_STEPS];
   logic        ev_ovf_ff  [0:DIV_STEPS];
   logic [31:0] vv_rem_ff  [0:DIV_STEPS];
   logic [31:0] vv_bits_ff [0:DIV_STEPS];
   logic [31:0] vv_q_ff    [0:DIV_STEPS];
   logic        vv_ovf_ff  [0:DIV_STEPS];
   carry_type   dv0_c_in;
   logic [63:0] dv0_root;

   // ---------------- output register ----------------
   logic        out_v_ff;
   logic [31:0] out_val_ff, out_val_in;
   logic [30:0] out_err_ff, out_err_in;
   logic        out_less_ff;
   stat_type    out_st_ff, out_st_in;
   carry_type   fc;
   logic [31:0] fq_v, fq_vneg, fval_div;
   logic [30:0] ferr_div;
   logic        fvsat, fesat;

   // global advance: hold everything while a result waits
   assign adv       = !(out_v_ff && rsp_stall);
   assign req_stall = !adv;

   // stage 0
   assign s0_mva_in = req_a_value[31] ? 32'(-req_a_value) : req_a_value;
   assign s0_mvb_in = req_b_value[31] ? 32'(-req_b_value) : req_b_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_cmd_ff  <= cmd_type'(req_command);
         s0_va_ff   <= req_a_value;
         s0_vb_ff   <= req_b_value;
         s0_mva_ff  <= s0_mva_in;
         s0_mvb_ff  <= s0_mvb_in;
         s0_ea_ff   <= req_a_error;
         s0_eb_ff   <= req_b_error;
         s0_neg_ff  <= req_a_value[31] ^ req_b_value[31];
         s0_less_ff <= req_a_value < req_b_value;
      end
   end

   // stage 1
   assign s1_prod_in = s0_mva_ff * s0_mvb_ff;
   assign s1_p1_in   = s0_mvb_ff * {1'b0, s0_ea_ff};
   assign s1_p2_in   = s0_mva_ff * {1'b0, s0_eb_ff};
   assign s1_d2_in   = s0_mvb_ff * s0_mvb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= s0_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cmd_ff  <= s0_cmd_ff;
         s1_prod_ff <= s1_prod_in;
         s1_p1_ff   <= s1_p1_in[62:0];
         s1_p2_ff   <= s1_p2_in[62:0];
         s1_d2_ff   <= s1_d2_in[62:0];
         s1_sum_ff  <= {s0_va_ff[31], s0_va_ff} + {s0_vb_ff[31], s0_vb_ff};
         s1_neg_ff  <= s0_neg_ff;
         s1_less_ff <= s0_less_ff;
         s1_ea_ff   <= s0_ea_ff;
         s1_eb_ff   <= s0_eb_ff;
         s1_mva_ff  <= s0_mva_ff;
         s1_vd_d_ff <= (s0_cmd_ff == CMD_SIG) ? {1'b0, s0_ea_ff} : s0_mvb_ff;
         s1_vneg_ff <= (s0_cmd_ff == CMD_SIG) ? s0_va_ff[31] : s0_neg_ff;
         s1_zdiv_ff <= ((s0_cmd_ff == CMD_DIV) && (s0_mvb_ff == 32'd0)) ||
                       ((s0_cmd_ff == CMD_SIG) && (s0_ea_ff == 31'd0));
      end
   end

   // stage 2: saturate value and scale error, pick square operands
   assign s2_mag  = s1_prod_ff[63:16];
   assign s2_serr = s1_p1_ff[62:16];
   assign s2_msat = s1_neg_ff ? (s2_mag > 48'h0000_8000_0000) : (|s2_mag[47:31]);

   always_comb begin
      s2_c_in            = '0;
      s2_c_in.cmd        = s1_cmd_ff;
      s2_c_in.less       = s1_less_ff;
      s2_c_in.vneg       = s1_vneg_ff;
      s2_c_in.zdiv       = s1_zdiv_ff;
      s2_c_in.vd_n       = s1_mva_ff;
      s2_c_in.vd_d       = s1_vd_d_ff;
      s2_c_in.ed_d       = s1_d2_ff;
      case (s1_cmd_ff)
         CMD_ADD: begin
            s2_c_in.early_vsat = s1_sum_ff[32] != s1_sum_ff[31];
            if (s1_sum_ff[32] != s1_sum_ff[31]) begin
               s2_c_in.early_val = s1_sum_ff[32] ? VAL_MIN : VAL_MAX;
            end else begin
               s2_c_in.early_val = s1_sum_ff[31:0];
            end
         end
         CMD_MUL, CMD_SCALE: begin
            s2_c_in.early_vsat = s2_msat;
            if (s2_msat) begin
               s2_c_in.early_val = s1_neg_ff ? VAL_MIN : VAL_MAX;
            end else begin
               s2_c_in.early_val = s1_neg_ff ? 32'(-s2_mag[31:0]) : s2_mag[31:0];
            end
            if (s1_cmd_ff == CMD_SCALE) begin
               s2_c_in.early_esat = |s2_serr[46:31];
               s2_c_in.early_err  = (|s2_serr[46:31]) ? MAX_ERR : s2_serr[30:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_c_ff  <= s2_c_in;
         s2_x1_ff <= (s1_cmd_ff == CMD_ADD) ? {32'd0, s1_ea_ff} : s1_p1_ff;
         s2_x2_ff <= (s1_cmd_ff == CMD_ADD) ? {32'd0, s1_eb_ff} : s1_p2_ff;
      end
   end

   // stage 3: partial products of the low and high halves of both square operands
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_c_ff   <= s2_c_ff;
         s3_ll1_ff <= s2_x1_ff[31:0] * s2_x1_ff[31:0];
         s3_lh1_ff <= s2_x1_ff[31:0] * s2_x1_ff[62:32];
         s3_hh1_ff <= s2_x1_ff[62:32] * s2_x1_ff[62:32];
         s3_ll2_ff <= s2_x2_ff[31:0] * s2_x2_ff[31:0];
         s3_lh2_ff <= s2_x2_ff[31:0] * s2_x2_ff[62:32];
         s3_hh2_ff <= s2_x2_ff[62:32] * s2_x2_ff[62:32];
      end
   end

   // stage 4: assemble each square
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (adv) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_c_ff   <= s3_c_ff;
         s4_sq1_ff <= {2'd0, s3_hh1_ff, 64'd0} + {32'd0, s3_lh1_ff, 33'd0} +
                      {64'd0, s3_ll1_ff};
         s4_sq2_ff <= {2'd0, s3_hh2_ff, 64'd0} + {32'd0, s3_lh2_ff, 33'd0} +
                      {64'd0, s3_ll2_ff};
      end
   end

   // root section entry: radicand is the sum of squares
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_c_ff[0]    <= s4_c_ff;
         sq_n_ff[0]    <= s4_sq1_ff + s4_sq2_ff;
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
      end
   end

   // one root bit per stage, two radicand bits brought down
   for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
      logic [65:0] cur_w, trial_w, diff_w;
      logic        ge;
      logic [64:0] rem_in;

      assign cur_w   = {sq_rem_ff[k-1][63:0], sq_n_ff[k-1][127:126]};
      assign trial_w = {sq_root_ff[k-1], 2'b01};
      assign ge      = cur_w >= trial_w;
      assign diff_w  = cur_w - trial_w;
      assign rem_in  = ge ? diff_w[64:0] : cur_w[64:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k] <= sq_v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_c_ff[k]    <= sq_c_ff[k-1];
            sq_n_ff[k]    <= {sq_n_ff[k-1][125:0], 2'b00};
            sq_rem_ff[k]  <= rem_in;
            sq_root_ff[k] <= {sq_root_ff[k-1][62:0], ge};
         end
      end
   end

   // divide entry: finish add and multiply errors, set up both divisions
   assign dv0_root = sq_root_ff[SQRT_STEPS];

   always_comb begin
      dv0_c_in = sq_c_ff[SQRT_STEPS];
      case (sq_c_ff[SQRT_STEPS].cmd)
         CMD_ADD: begin
            dv0_c_in.early_esat = |dv0_root[63:31];
            dv0_c_in.early_err  = (|dv0_root[63:31]) ? MAX_ERR : dv0_root[30:0];
         end
         CMD_MUL: begin
            dv0_c_in.early_esat = |dv0_root[63:47];
            dv0_c_in.early_err  = (|dv0_root[63:47]) ? MAX_ERR : dv0_root[46:16];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= sq_v_ff[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_c_ff[0]    <= dv0_c_in;
         ev_rem_ff[0]  <= {15'd0, dv0_root[63:16]};
         ev_bits_ff[0] <= {dv0_root[15:0], 16'd0};
         ev_q_ff[0]    <= '0;
         ev_ovf_ff[0]  <= {15'd0, dv0_root[63:16]} >= sq_c_ff[SQRT_STEPS].ed_d;
         vv_rem_ff[0]  <= {16'd0, sq_c_ff[SQRT_STEPS].vd_n[31:16]};
         vv_bits_ff[0] <= {sq_c_ff[SQRT_STEPS].vd_n[15:0], 16'd0};
         vv_q_ff[0]    <= '0;
         vv_ovf_ff[0]  <= {16'd0, sq_c_ff[SQRT_STEPS].vd_n[31:16]} >=
                          sq_c_ff[SQRT_STEPS].vd_d;
      end
   end

   // one quotient bit per stage for error and value
   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
      logic [63:0] e_cur, e_diff;
      logic        e_ge;
      logic [32:0] v_cur, v_diff;
      logic        v_ge;

      assign e_cur  = {ev_rem_ff[k-1], ev_bits_ff[k-1][31]};
      assign e_ge   = e_cur >= {1'b0, dv_c_ff[k-1].ed_d};
      assign e_diff = e_cur - {1'b0, dv_c_ff[k-1].ed_d};
      assign v_cur  = {vv_rem_ff[k-1], vv_bits_ff[k-1][31]};
      assign v_ge   = v_cur >= {1'b0, dv_c_ff[k-1].vd_d};
      assign v_diff = v_cur - {1'b0, dv_c_ff[k-1].vd_d};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[k] <= dv_v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_c_ff[k]    <= dv_c_ff[k-1];
            ev_rem_ff[k]  <= e_ge ? e_diff[62:0] : e_cur[62:0];
            ev_bits_ff[k] <= {ev_bits_ff[k-1][30:0], 1'b0};
            ev_q_ff[k]    <= {ev_q_ff[k-1][30:0], e_ge};
            ev_ovf_ff[k]  <= ev_ovf_ff[k-1];
            vv_rem_ff[k]  <= v_ge ? v_diff[31:0] : v_cur[31:0];
            vv_bits_ff[k] <= {vv_bits_ff[k-1][30:0], 1'b0};
            vv_q_ff[k]    <= {vv_q_ff[k-1][30:0], v_ge};
            vv_ovf_ff[k]  <= vv_ovf_ff[k-1];
         end
      end
   end

   // final select and saturation
   assign fc       = dv_c_ff[DIV_STEPS];
   assign fq_v     = vv_q_ff[DIV_STEPS];
   assign fq_vneg  = 32'(-fq_v);
   assign fvsat    = vv_ovf_ff[DIV_STEPS] ||
                     (fc.vneg ? (fq_v > VAL_MIN) : fq_v[31]);
   assign fval_div = fvsat ? (fc.vneg ? VAL_MIN : VAL_MAX) :
                             (fc.vneg ? fq_vneg : fq_v);
   assign fesat    = ev_ovf_ff[DIV_STEPS] || ev_q_ff[DIV_STEPS][31];
   assign ferr_div = fesat ? MAX_ERR : ev_q_ff[DIV_STEPS][30:0];

   always_comb begin
      out_val_in = '0;
      out_err_in = '0;
      out_st_in  = ST_OK;
      case (fc.cmd)
         CMD_ADD, CMD_MUL, CMD_SCALE: begin
            out_val_in = fc.early_val;
            out_err_in = fc.early_err;
            out_st_in  = (fc.early_vsat || fc.early_esat) ? ST_SAT : ST_OK;
         end
         CMD_DIV: begin
            if (fc.zdiv) begin
               out_st_in = ST_DIV_ZERO;
            end else begin
               out_val_in = fval_div;
               out_err_in = ferr_div;
               out_st_in  = (fvsat || fesat) ? ST_SAT : ST_OK;
            end
         end
         CMD_SIG: begin
            if (fc.zdiv) begin
               out_st_in = ST_DIV_ZERO;
            end else begin
               out_val_in = fval_div;
               out_st_in  = fvsat ? ST_SAT : ST_OK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_v_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_val_ff  <= out_val_in;
         out_err_ff  <= out_err_in;
         out_less_ff <= fc.less;
         out_st_ff   <= out_st_in;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_result_value = out_val_ff;
   assign rsp_result_error = out_err_ff;
   assign rsp_less_flag    = out_less_ff;
   assign rsp_status       = out_st_ff;

endmodule
